// ----- hdl/urfm_pkg.sv -----
// Shared types and constants of the register frame master.
package urfm_pkg;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned STEP_W = 4;

  localparam logic [7:0] CMD_READ_BYTE  = 8'h58;
  localparam logic [7:0] CMD_WRITE_BYTE = 8'hA8;
  localparam logic [7:0] UNLOCK_ADDR    = 8'h1A;
  localparam logic [7:0] UNLOCK_KEY     = 8'h55;
  localparam logic [7:0] UNLOCK_PAD     = 8'h00;
  localparam logic [7:0] UNLOCK_CKSUM   =
    ~(CMD_WRITE_BYTE + UNLOCK_ADDR + UNLOCK_KEY + UNLOCK_PAD + UNLOCK_PAD);

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [15:0] WAIT_MAX      = 16'hFFFF;

  // Register index taken from paddr[2].
  localparam logic REG_TIMEOUT = 1'b0;

  localparam logic [STEP_W-1:0] LAST_READ_STEP  = 4'd1;
  localparam logic [STEP_W-1:0] LAST_WRITE_STEP = 4'd11;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RX    = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_CKSUM   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    JOB_READ  = 2'd0,
    JOB_WRITE = 2'd1,
    JOB_DONE  = 2'd2
  } job_kind_e;

  typedef enum logic {
    RES_TX   = 1'b0,
    RES_DONE = 1'b1
  } res_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [7:0]  addr;
    logic [23:0] data;
    status_e     status;
  } job_t;

  typedef struct packed {
    res_kind_e   kind;
    logic [7:0]  tx;
    logic [23:0] data;
    status_e     status;
    logic        last;
  } res_t;

endpackage

// ----- hdl/urfm_front.sv -----
// Front end: accepts requests, tracks the pending read and queues frame jobs.
module urfm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          command_i,
  input  logic [7:0]          address_i,
  input  logic [23:0]         write_data_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [15:0]         timeout_i,
  output logic                jq_push_o,
  output urfm_pkg::job_t      jq_job_o
);

  logic        pending_q, pending_d;
  logic [2:0]  count_q, count_d;
  logic [23:0] value_q, value_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] wait_q, wait_d;
  logic [15:0] wait_inc;

  always_comb begin
    pending_d = pending_q;
    count_d   = count_q;
    value_d   = value_q;
    sum_d     = sum_q;
    wait_d    = wait_q;
    jq_push_o = 1'b0;
    jq_job_o  = '{kind: urfm_pkg::JOB_READ, addr: address_i, data: write_data_i,
                  status: urfm_pkg::ST_OK};
    wait_inc  = (wait_q < urfm_pkg::WAIT_MAX) ? wait_q + 16'd1 : wait_q;
    if (accept_i) begin
      case (urfm_pkg::cmd_e'(command_i))
        urfm_pkg::CMD_READ: begin
          if (!pending_q) begin
            jq_push_o = 1'b1;
            pending_d = 1'b1;
            count_d   = 3'd0;
            value_d   = 24'd0;
            sum_d     = urfm_pkg::CMD_READ_BYTE + address_i;
            wait_d    = 16'd0;
          end
        end
        urfm_pkg::CMD_WRITE: begin
          if (!pending_q) begin
            jq_push_o     = 1'b1;
            jq_job_o.kind = urfm_pkg::JOB_WRITE;
          end
        end
        urfm_pkg::CMD_RX: begin
          if (pending_q) begin
            if (count_q < 3'd3) begin
              case (count_q)
                3'd0:    value_d[7:0]   = rx_byte_i;
                3'd1:    value_d[15:8]  = rx_byte_i;
                default: value_d[23:16] = rx_byte_i;
              endcase
              sum_d   = sum_q + rx_byte_i;
              count_d = count_q + 3'd1;
            end else begin
              pending_d     = 1'b0;
              count_d       = 3'd0;
              jq_push_o     = 1'b1;
              jq_job_o.kind = urfm_pkg::JOB_DONE;
              if (~sum_q == rx_byte_i) begin
                jq_job_o.data   = value_q;
                jq_job_o.status = urfm_pkg::ST_OK;
              end else begin
                jq_job_o.data   = 24'd0;
                jq_job_o.status = urfm_pkg::ST_CKSUM;
              end
            end
          end
        end
        default: begin
          if (pending_q) begin
            wait_d = wait_inc;
            if (wait_inc >= timeout_i) begin
              pending_d       = 1'b0;
              count_d         = 3'd0;
              jq_push_o       = 1'b1;
              jq_job_o.kind   = urfm_pkg::JOB_DONE;
              jq_job_o.data   = 24'd0;
              jq_job_o.status = urfm_pkg::ST_TIMEOUT;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      count_q   <= 3'd0;
      value_q   <= 24'd0;
      sum_q     <= 8'd0;
      wait_q    <= 16'd0;
    end else begin
      pending_q <= pending_d;
      count_q   <= count_d;
      value_q   <= value_d;
      sum_q     <= sum_d;
      wait_q    <= wait_d;
    end
  end

`ifndef ASSERT_OFF
  // A read only ends by queuing its completion.
  a_end_queues_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(pending_q) |-> $past(jq_push_o && jq_job_o.kind == urfm_pkg::JOB_DONE))
    else $error("read ended without a completion job");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'd3)
    else $error("reply byte count out of range");
`endif

endmodule

// ----- hdl/urfm_jobq.sv -----
// Two-entry job queue between the front end and the frame sequencer.
module urfm_jobq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  urfm_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output urfm_pkg::job_t head_o
);

  urfm_pkg::job_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job queue underflow");
`endif

endmodule

// ----- hdl/urfm_back.sv -----
// Frame sequencer: expands jobs into result bytes and holds the result queue.
module urfm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           jq_empty_i,
  input  urfm_pkg::job_t head_i,
  output logic           jq_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output urfm_pkg::res_t res_o
);

  logic [urfm_pkg::STEP_W-1:0] step_q, step_d;
  urfm_pkg::res_t res_d;
  urfm_pkg::res_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           emit;
  logic           deq;
  logic [7:0]     write_cksum;

  assign empty_o = (cnt_q == 2'd0);
  assign res_o   = mem_q[rd_ptr_q];
  assign deq     = pop_i && !empty_o;
  assign emit    = !jq_empty_i && ((cnt_q != 2'd2) || deq);
  assign jq_pop_o = emit && res_d.last;

  assign write_cksum = ~(urfm_pkg::CMD_WRITE_BYTE + head_i.addr + head_i.data[7:0]
                         + head_i.data[15:8] + head_i.data[23:16]);

  always_comb begin
    res_d = '{kind: urfm_pkg::RES_TX, tx: 8'd0, data: 24'd0,
              status: urfm_pkg::ST_OK, last: 1'b0};
    unique case (head_i.kind)
      urfm_pkg::JOB_READ: begin
        res_d.tx   = (step_q == '0) ? urfm_pkg::CMD_READ_BYTE : head_i.addr;
        res_d.last = (step_q == urfm_pkg::LAST_READ_STEP);
      end
      urfm_pkg::JOB_WRITE: begin
        case (step_q)
          4'd0:    res_d.tx = urfm_pkg::CMD_WRITE_BYTE;
          4'd1:    res_d.tx = urfm_pkg::UNLOCK_ADDR;
          4'd2:    res_d.tx = urfm_pkg::UNLOCK_KEY;
          4'd3:    res_d.tx = urfm_pkg::UNLOCK_PAD;
          4'd4:    res_d.tx = urfm_pkg::UNLOCK_PAD;
          4'd5:    res_d.tx = urfm_pkg::UNLOCK_CKSUM;
          4'd6:    res_d.tx = urfm_pkg::CMD_WRITE_BYTE;
          4'd7:    res_d.tx = head_i.addr;
          4'd8:    res_d.tx = head_i.data[7:0];
          4'd9:    res_d.tx = head_i.data[15:8];
          4'd10:   res_d.tx = head_i.data[23:16];
          default: res_d.tx = write_cksum;
        endcase
        res_d.last = (step_q == urfm_pkg::LAST_WRITE_STEP);
      end
      urfm_pkg::JOB_DONE: begin
        res_d.kind   = urfm_pkg::RES_DONE;
        res_d.data   = head_i.data;
        res_d.status = head_i.status;
        res_d.last   = 1'b1;
      end
      default: begin
        res_d.last = 1'b1;
      end
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (emit) begin
      step_d = res_d.last ? '0 : step_q + 4'd1;
    end
    wr_ptr_d = emit ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = deq ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, emit} - {1'b0, deq};
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      mem_q[wr_ptr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      step_q   <= step_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("result queue count out of range");
  a_step_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !res_d.last) |=> step_q == $past(step_q) + 4'd1)
    else $error("sequencer step did not advance");
  a_step_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jq_pop_o |=> step_q == '0)
    else $error("sequencer step not cleared after a job");
`endif

endmodule

// ----- hdl/uart_register_frame_master_core.sv -----
// Top level of the register frame master: queue ports, APB register and the three parts.
//
// The block turns register requests into the byte stream of a serial register link
// and checks the replies. Every input request carries a command: a read request
// queues the read command byte and the address and opens a pending read; a write
// request queues twelve bytes, a fixed unlock frame and then the write frame with
// the address, three data bytes least significant first and an inverted-sum
// checksum; a received byte is collected only while a read is pending, and the
// fourth reply byte closes the read with a completion of status ok or checksum
// error; a time tick counts toward the timeout_ticks register and closes the read
// with status timeout when the count reaches it. Requests made while a read is
// pending, received bytes and ticks with no read pending produce nothing. The
// front end classifies one request per clock as long as its two-entry job queue
// has room, so requests may follow back to back. The frame sequencer behind it
// writes one result per clock, while it has a job and the result queue has room, into
// a two-entry result queue: a write request yields twelve results, a read request two
// and a completion one; that sequencer, one result byte a cycle, sets the sustained
// rate. The last signal marks each request's final result, if any. The timeout_ticks
// register sits at byte address 0 of the APB port and resets to 100; it should
// only be written while the block is idle.
module uart_register_frame_master_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request side.
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    command_i,
  input  logic [7:0]                    address_i,
  input  logic [23:0]                   write_data_i,
  input  logic [7:0]                    rx_byte_i,
  // Result side.
  output logic                          empty,
  input  logic                          pop,
  output logic                          kind_o,
  output logic [7:0]                    tx_byte_o,
  output logic [23:0]                   read_data_o,
  output logic [1:0]                    status_o,
  output logic                          last_o,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [urfm_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [15:0]    timeout_q, timeout_d;
  logic           accept;
  logic           jq_push;
  urfm_pkg::job_t jq_job;
  logic           jq_full;
  logic           jq_empty;
  logic           jq_pop;
  urfm_pkg::job_t jq_head;
  urfm_pkg::res_t res;

  // A request is taken whenever the job queue has room, even one that will
  // produce no result.
  assign full   = jq_full;
  assign accept = push && !jq_full;

  // The APB port never stalls; only the timeout register is decoded.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == urfm_pkg::REG_TIMEOUT) ? {16'd0, timeout_q} : 32'd0;

  always_comb begin
    timeout_d = timeout_q;
    if (psel && penable && pwrite && paddr[2] == urfm_pkg::REG_TIMEOUT) begin
      timeout_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= urfm_pkg::TIMEOUT_RESET;
    end else begin
      timeout_q <= timeout_d;
    end
  end

  urfm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .command_i    (command_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .rx_byte_i    (rx_byte_i),
    .timeout_i    (timeout_q),
    .jq_push_o    (jq_push),
    .jq_job_o     (jq_job)
  );

  urfm_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (jq_push),
    .job_i   (jq_job),
    .full_o  (jq_full),
    .pop_i   (jq_pop),
    .empty_o (jq_empty),
    .head_o  (jq_head)
  );

  urfm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .jq_empty_i (jq_empty),
    .head_i     (jq_head),
    .jq_pop_o   (jq_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .res_o      (res)
  );

  assign kind_o      = res.kind;
  assign tx_byte_o   = res.tx;
  assign read_data_o = res.data;
  assign status_o    = res.status;
  assign last_o      = res.last;

endmodule

// ----- tb/urfm_link_checker.sv -----
// Checker for the register frame master: predicts every result and compares the output channel.
module urfm_link_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  input  logic                        full,
  input  logic [1:0]                  command_i,
  input  logic [7:0]                  address_i,
  input  logic [23:0]                 write_data_i,
  input  logic [7:0]                  rx_byte_i,
  input  logic                        empty,
  input  logic                        pop,
  input  logic                        kind_i,
  input  logic [7:0]                  tx_byte_i,
  input  logic [23:0]                 read_data_i,
  input  logic [1:0]                  status_i,
  input  logic                        last_i,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [urfm_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic [31:0]                 prdata,
  input  logic                        pready,
  output int unsigned                 fail_count_o,
  output int unsigned                 open_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import urfm_pkg::*;

  logic [15:0] timeout_cfg;
  logic        read_open;
  logic [2:0]  reply_cnt;
  logic [23:0] reply_acc;
  logic [7:0]  reply_sum;
  logic [15:0] tick_cnt;
  res_t        link_results_q [$];
  int unsigned mismatches;

  function automatic string describe(res_t r);
    return $sformatf("kind=%0d tx=%02h data=%06h status=%0d last=%0d",
                     r.kind, r.tx, r.data, r.status, r.last);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endfunction

  function automatic void expect_tx(logic [7:0] b, logic fin);
    res_t r;
    r = '0;
    r.kind = RES_TX;
    r.tx = b;
    r.last = fin;
    link_results_q.push_back(r);
  endfunction

  function automatic void expect_completion(status_e st, logic [23:0] value);
    res_t r;
    r = '0;
    r.kind = RES_DONE;
    r.data = value;
    r.status = st;
    r.last = 1'b1;
    link_results_q.push_back(r);
  endfunction

  // Five payload bytes followed by the inverted eight-bit sum of them.
  function automatic void expect_frame(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                       logic [7:0] b3, logic [7:0] b4, logic fin);
    logic [7:0] sum;
    sum = b0 + b1 + b2 + b3 + b4;
    expect_tx(b0, 1'b0);
    expect_tx(b1, 1'b0);
    expect_tx(b2, 1'b0);
    expect_tx(b3, 1'b0);
    expect_tx(b4, 1'b0);
    expect_tx(~sum, fin);
  endfunction

  function automatic void predict_request(cmd_e cmd, logic [7:0] addr, logic [23:0] wdata,
                                          logic [7:0] rx);
    case (cmd)
      CMD_READ: begin
        if (!read_open) begin
          expect_tx(CMD_READ_BYTE, 1'b0);
          expect_tx(addr, 1'b1);
          read_open = 1'b1;
          reply_cnt = '0;
          reply_acc = '0;
          reply_sum = CMD_READ_BYTE + addr;
          tick_cnt = '0;
        end
      end
      CMD_WRITE: begin
        if (!read_open) begin
          expect_frame(CMD_WRITE_BYTE, UNLOCK_ADDR, UNLOCK_KEY, UNLOCK_PAD, UNLOCK_PAD, 1'b0);
          expect_frame(CMD_WRITE_BYTE, addr, wdata[7:0], wdata[15:8], wdata[23:16], 1'b1);
        end
      end
      CMD_RX: begin
        if (read_open) begin
          if (reply_cnt < 3) begin
            reply_acc = reply_acc | (24'(rx) << (8 * reply_cnt));
            reply_sum = reply_sum + rx;
            reply_cnt = reply_cnt + 3'd1;
          end else begin
            read_open = 1'b0;
            reply_cnt = '0;
            if (~reply_sum == rx) begin
              expect_completion(ST_OK, reply_acc);
            end else begin
              expect_completion(ST_CKSUM, '0);
            end
          end
        end
      end
      CMD_TICK: begin
        if (read_open) begin
          if (tick_cnt != WAIT_MAX) begin
            tick_cnt = tick_cnt + 16'd1;
          end
          if (tick_cnt >= timeout_cfg) begin
            read_open = 1'b0;
            reply_cnt = '0;
            expect_completion(ST_TIMEOUT, '0);
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    res_t seen;
    res_t want;
    if (!rst_ni) begin
      timeout_cfg = TIMEOUT_RESET;
      read_open = 1'b0;
      reply_cnt = '0;
      reply_acc = '0;
      reply_sum = '0;
      tick_cnt = '0;
      link_results_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      open_count_o <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_TIMEOUT) begin
            timeout_cfg = pwdata[15:0];
          end
        end else if (prdata !== {16'h0, timeout_cfg}) begin
          note_mismatch($sformatf("register read expected %08h got %08h",
                                  {16'h0, timeout_cfg}, prdata));
        end
      end
      if (push && !full) begin
        predict_request(cmd_e'(command_i), address_i, write_data_i, rx_byte_i);
      end
      if (pop && !empty) begin
        seen = '0;
        seen.kind = res_kind_e'(kind_i);
        seen.tx = tx_byte_i;
        seen.data = read_data_i;
        seen.status = status_e'(status_i);
        seen.last = last_i;
        if (link_results_q.size() == 0) begin
          note_mismatch({"result with nothing expected: ", describe(seen)});
        end else begin
          want = link_results_q.pop_front();
          if (seen.kind !== want.kind || seen.tx !== want.tx || seen.data !== want.data ||
              seen.status !== want.status || seen.last !== want.last) begin
            note_mismatch({"expected ", describe(want), " got ", describe(seen)});
          end
        end
      end
      fail_count_o <= mismatches;
      open_count_o <= link_results_q.size();
    end
  end

endmodule

// ----- tb/uart_register_frame_master_core_test.sv -----
// Testbench top of the register frame master: clock, reset, stimulus, configuration and verdict.
module uart_register_frame_master_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import urfm_pkg::*;

  // Cycles allowed after the last expected result for requests that produce nothing.
  localparam int unsigned DRAIN_CYCLES = 32;
  // Length of the one long stall on the result side.
  localparam int unsigned RX_HOLD_CYCLES = 300;
  // The timeout register is register 0, so it sits at byte address 0.
  localparam logic [APB_AW-1:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};

  logic              clk_i;
  logic              rst_ni;
  logic              push;
  logic              full;
  logic [1:0]        command_i;
  logic [7:0]        address_i;
  logic [23:0]       write_data_i;
  logic [7:0]        rx_byte_i;
  logic              empty;
  logic              pop;
  logic              kind_o;
  logic [7:0]        tx_byte_o;
  logic [23:0]       read_data_o;
  logic [1:0]        status_o;
  logic              last_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int unsigned fail_count;
  int unsigned open_count;
  int unsigned items_sent;
  // When set, neither side idles any more.
  bit          calm_phase;
  // Raised by the stimulus to ask the receiver for one long stall.
  bit          hold_pop;

  uart_register_frame_master_core u_top (
    .clk_i, .rst_ni,
    .push, .full, .command_i, .address_i, .write_data_i, .rx_byte_i,
    .empty, .pop, .kind_o, .tx_byte_o, .read_data_o, .status_o, .last_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  urfm_link_checker u_checker (
    .clk_i, .rst_ni,
    .push, .full, .command_i, .address_i, .write_data_i, .rx_byte_i,
    .empty, .pop,
    .kind_i      (kind_o),
    .tx_byte_i   (tx_byte_o),
    .read_data_i (read_data_o),
    .status_i    (status_o),
    .last_i      (last_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count_o (fail_count),
    .open_count_o (open_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a healthy run is far shorter than this.
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // The checksum that the metering chip sends after three data bytes: the inverted sum
  // of the read command byte, the address and the data bytes.
  function automatic logic [7:0] reply_cksum(logic [7:0] addr, logic [7:0] b0,
                                             logic [7:0] b1, logic [7:0] b2);
    logic [7:0] sum;
    sum = CMD_READ_BYTE + addr + b0 + b1 + b2;
    return ~sum;
  endfunction

  // Offers one request and returns at the edge where it was accepted. Before it, the
  // sender may idle for a short random burst. push stays high on return, so a following
  // request goes out back to back; whoever stops sending lowers it in that same step.
  task automatic offer_request(cmd_e cmd, logic [7:0] addr, logic [23:0] wdata,
                               logic [7:0] rx);
    int unsigned gap;
    gap = 0;
    if (!calm_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
    end
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push         <= 1'b1;
    command_i    <= cmd;
    address_i    <= addr;
    write_data_i <= wdata;
    rx_byte_i    <= rx;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  // Stops sending and waits until every expected result has come out, then lets the
  // block finish any request that produces nothing (stray bytes, ticks).
  task automatic wait_link_idle();
    push <= 1'b0;
    @(posedge clk_i);
    wait (open_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes the reply timeout while the block is idle, then reads it back; the checker
  // compares the read data with its own copy of the register.
  task automatic set_reply_timeout(logic [15:0] ticks);
    wait_link_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TIMEOUT_ADDR;
    pwdata  <= {16'h0, ticks};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // Straight into the setup phase of the read; psel stays high.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One read exchange as the chip would answer it: the read request, three data bytes and
  // a checksum that is mostly right. Now and then a tick or a request that must be ignored
  // slips in between the reply bytes.
  task automatic run_read_exchange();
    logic [7:0] addr;
    logic [7:0] data [3];
    logic [7:0] cksum;
    addr = 8'($urandom);
    offer_request(CMD_READ, addr, 24'($urandom), 8'($urandom));
    for (int i = 0; i < 3; i++) begin
      data[i] = 8'($urandom);
      if ($urandom_range(0, 5) == 0) begin
        offer_request(CMD_TICK, 8'($urandom), 24'($urandom), 8'($urandom));
      end
      if ($urandom_range(0, 11) == 0) begin
        offer_request($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, 8'($urandom),
                      24'($urandom), 8'($urandom));
      end
      offer_request(CMD_RX, 8'($urandom), 24'($urandom), data[i]);
    end
    cksum = reply_cksum(addr, data[0], data[1], data[2]);
    if ($urandom_range(0, 4) == 0) begin
      cksum = cksum ^ (8'd1 << $urandom_range(0, 7));
    end
    offer_request(CMD_RX, 8'($urandom), 24'($urandom), cksum);
  endtask

  // Random traffic for one timeout setting. Most of it is well-formed read exchanges and
  // write requests; the rest is noise with any command and, for short timeouts, a read
  // that is left to run into its timeout.
  task automatic random_traffic(int unsigned count, logic [15:0] ticks);
    int unsigned first;
    int unsigned pick;
    first = items_sent;
    while (items_sent - first < count) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        run_read_exchange();
      end else if (pick <= 7) begin
        offer_request(CMD_WRITE, 8'($urandom), 24'($urandom), 8'($urandom));
      end else if (pick == 8) begin
        offer_request(cmd_e'($urandom_range(0, 3)), 8'($urandom), 24'($urandom),
                      8'($urandom));
      end else if (ticks <= 40) begin
        offer_request(CMD_READ, 8'($urandom), 24'($urandom), 8'($urandom));
        repeat (ticks + 1) offer_request(CMD_TICK, 8'($urandom), 24'($urandom),
                                         8'($urandom));
      end else begin
        run_read_exchange();
      end
    end
  endtask

  // Result side: pops in random runs with random idle bursts in between, and once, on
  // request, one long stall so that the block fills up and holds off requests.
  initial begin : receiver
    pop <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_pop) begin
        pop <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        hold_pop = 1'b0;
      end else if (calm_phase || $urandom_range(0, 3) != 0) begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    items_sent   = 0;
    calm_phase   = 1'b0;
    hold_pop     = 1'b0;
    push         <= 1'b0;
    command_i    <= CMD_READ;
    address_i    <= '0;
    write_data_i <= '0;
    rx_byte_i    <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    rst_ni       <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, first with the timeout left at its reset value.
    // Write frames with the extreme address and data values.
    offer_request(CMD_WRITE, 8'h00, 24'h000000, 8'h00);
    offer_request(CMD_WRITE, 8'hFF, 24'hFFFFFF, 8'hFF);
    // A received byte and a tick with no read pending are dropped.
    offer_request(CMD_RX, 8'h00, 24'h000000, 8'hFF);
    offer_request(CMD_TICK, 8'h00, 24'h000000, 8'h00);
    // A read with a correct reply.
    offer_request(CMD_READ, 8'h00, 24'h000000, 8'h00);
    offer_request(CMD_RX, 8'h00, 24'h000000, 8'hFF);
    offer_request(CMD_RX, 8'h00, 24'h000000, 8'h00);
    offer_request(CMD_RX, 8'h00, 24'h000000, 8'h80);
    offer_request(CMD_RX, 8'h00, 24'h000000, reply_cksum(8'h00, 8'hFF, 8'h00, 8'h80));
    // A read during which further requests must be ignored, closed by a bad checksum.
    offer_request(CMD_READ, 8'hFF, 24'h000000, 8'h00);
    offer_request(CMD_READ, 8'h5A, 24'h000000, 8'h00);
    offer_request(CMD_WRITE, 8'h5A, 24'h123456, 8'h00);
    offer_request(CMD_RX, 8'h00, 24'h000000, 8'h12);
    offer_request(CMD_RX, 8'h00, 24'h000000, 8'h34);
    offer_request(CMD_RX, 8'h00, 24'h000000, 8'h56);
    offer_request(CMD_RX, 8'h00, 24'h000000,
                  reply_cksum(8'hFF, 8'h12, 8'h34, 8'h56) ^ 8'h80);

    // A partial reply runs into the timeout; the byte after it is dropped.
    set_reply_timeout(16'd2);
    offer_request(CMD_READ, 8'hA5, 24'h000000, 8'h00);
    offer_request(CMD_RX, 8'h00, 24'h000000, 8'h77);
    offer_request(CMD_TICK, 8'h00, 24'h000000, 8'h00);
    offer_request(CMD_TICK, 8'h00, 24'h000000, 8'h00);
    offer_request(CMD_RX, 8'h00, 24'h000000, 8'h99);

    // With a zero timeout the first tick of a read ends it, and likewise with one.
    set_reply_timeout(16'd0);
    offer_request(CMD_READ, 8'h3C, 24'h000000, 8'h00);
    offer_request(CMD_TICK, 8'h00, 24'h000000, 8'h00);
    set_reply_timeout(16'd1);
    offer_request(CMD_READ, 8'hC3, 24'h000000, 8'h00);
    offer_request(CMD_TICK, 8'h00, 24'h000000, 8'h00);

    // Random part over several timeout settings.
    set_reply_timeout(16'd5);
    random_traffic(50, 16'd5);
    set_reply_timeout(16'd20);
    random_traffic(40, 16'd20);

    // Back pressure: the receiver stalls for a long stretch while write requests keep
    // coming, so both internal queues fill and full holds the sender off.
    hold_pop = 1'b1;
    repeat (8) offer_request(CMD_WRITE, 8'($urandom), 24'($urandom), 8'($urandom));

    // Last part at the largest timeout, with no idling on either side.
    set_reply_timeout(WAIT_MAX);
    calm_phase = 1'b1;
    random_traffic(50, WAIT_MAX);

    wait_link_idle();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
